/* hw/rtl/persian_arithmetic_date_converter_assert.svh */
// Assertion macros shared by the date converter RTL.
// Each macro checks on the rising edge of clk and is off while arst_n is low.
`ifndef PERSIAN_ARITHMETIC_DATE_CONVERTER_ASSERT_SVH
`define PERSIAN_ARITHMETIC_DATE_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define PDC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pdc: same-cycle check failed");

// Next-cycle implication.
`define PDC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pdc: next-cycle check failed");

`endif

/* hw/rtl/pdc_pkg.sv */
`timescale 1ns / 1ps

package pdc_pkg;

	// Command beat
	typedef struct packed {
		logic        kind;
		logic [13:0] in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
		logic [21:0] in_fixed_day;
	} pdc_in_t;

	// Result beat
	typedef struct packed {
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [21:0] out_fixed_day;
		logic        status;
	} pdc_out_t;

	// Calendar constants
	localparam logic [21:0] EpochFixed = 22'd226895;   // fixed day of 0001-01-01
	localparam logic [21:0] LimitFixed = 22'd3878954;  // fixed day of 10000-01-01
	localparam logic [13:0] MaxYear    = 14'd9999;
	localparam logic [21:0] DaysPerYr  = 22'd365;

	// floor(x/33) for x below 2^17: (x * K33) >> Q33Shift
	localparam logic [21:0] K33      = 22'd4067204;
	localparam int          Q33Shift = 27;
	// lower bound on elapsed years: (n * KYear) >> YearShift, about n*33/12053
	localparam logic [23:0] KYear     = 24'd11759223;
	localparam int          YearShift = 32;

	// Microcode
	typedef logic [3:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP    = 4'd0,
		OP_YMUL   = 4'd1,   // 365*(Y-1), floor((21+8Y)/33), floor((29+8Y)/33)
		OP_YSUM   = 4'd2,   // start of year Y, leap flag
		OP_FIXSUM = 4'd3,   // date to fixed day
		OP_SUBEP  = 4'd4,   // days since epoch
		OP_EST    = 4'd5,   // year lower bound
		OP_YINC   = 4'd6,   // advance year when the jump is taken
		OP_RDAY   = 4'd7,   // day of year
		OP_MON    = 4'd8,   // month from day of year
		OP_MDAY   = 4'd9,   // day of month
		OP_DONE   = 4'd10   // emit result beat
	} dp_op_t;

	typedef enum logic [2:0] {
		C_NEVER     = 3'd0,
		C_ALWAYS    = 3'd1,
		C_STATUS    = 3'd2,
		C_KIND      = 3'd3,
		C_YEAR_NEXT = 3'd4
	} cond_t;

	typedef struct packed {
		dp_op_t op;
		logic   ysel;    // 1: operate on year + 1
		cond_t  cond;
		step_t  target;
	} ucode_t;

	localparam step_t StepKind1    = 4'd5;
	localparam step_t StepYearLoop = 4'd7;
	localparam step_t StepDone     = 4'd15;

	// Days of the months before month m; past twelve counts the whole year
	function automatic logic [8:0] cum_days(logic [3:0] m, logic leap);
		logic [8:0] c;
		case (m)
			4'd0, 4'd1: c = 9'd0;
			4'd2:       c = 9'd31;
			4'd3:       c = 9'd62;
			4'd4:       c = 9'd93;
			4'd5:       c = 9'd124;
			4'd6:       c = 9'd155;
			4'd7:       c = 9'd186;
			4'd8:       c = 9'd216;
			4'd9:       c = 9'd246;
			4'd10:      c = 9'd276;
			4'd11:      c = 9'd306;
			4'd12:      c = 9'd336;
			default:    c = leap ? 9'd366 : 9'd365;
		endcase
		return c;
	endfunction

	// Month holding a zero-based day of year
	function automatic logic [3:0] month_of(logic [8:0] r);
		logic [3:0] m;
		m = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (r >= cum_days(4'(k), 1'b0))
				m = 4'(k);
		end
		return m;
	endfunction

	// Control store
	function automatic ucode_t ucode_rom(step_t pc);
		ucode_t w;
		unique case (pc)
			4'd0:  w = '{OP_NOP,    1'b0, C_STATUS,    StepDone};
			4'd1:  w = '{OP_NOP,    1'b0, C_KIND,      StepKind1};
			4'd2:  w = '{OP_YMUL,   1'b0, C_NEVER,     StepDone};
			4'd3:  w = '{OP_YSUM,   1'b0, C_NEVER,     StepDone};
			4'd4:  w = '{OP_FIXSUM, 1'b0, C_ALWAYS,    StepDone};
			4'd5:  w = '{OP_SUBEP,  1'b0, C_NEVER,     StepDone};
			4'd6:  w = '{OP_EST,    1'b0, C_NEVER,     StepDone};
			4'd7:  w = '{OP_YMUL,   1'b1, C_NEVER,     StepDone};
			4'd8:  w = '{OP_YSUM,   1'b1, C_NEVER,     StepDone};
			4'd9:  w = '{OP_YINC,   1'b0, C_YEAR_NEXT, StepYearLoop};
			4'd10: w = '{OP_YMUL,   1'b0, C_NEVER,     StepDone};
			4'd11: w = '{OP_YSUM,   1'b0, C_NEVER,     StepDone};
			4'd12: w = '{OP_RDAY,   1'b0, C_NEVER,     StepDone};
			4'd13: w = '{OP_MON,    1'b0, C_NEVER,     StepDone};
			4'd14: w = '{OP_MDAY,   1'b0, C_NEVER,     StepDone};
			4'd15: w = '{OP_DONE,   1'b0, C_NEVER,     StepDone};
			default: w = '{OP_DONE, 1'b0, C_NEVER,     StepDone};
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/persian_arithmetic_date_converter.sv */
`timescale 1ns / 1ps
// Arithmetic Persian calendar converter (33-year leap cycle).
// Command channel: drive cmd and raise start; the beat is taken at the rising
// edge where start is high and busy is low. busy rises the next cycle and
// stays high until the result is out.
// cmd.kind 0 turns year/month/day into a fixed day number; kind 1 turns a
// fixed day number into year/month/day. Unused fields of a result read zero.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall, so the beat must be taken in that cycle.
// status 1 flags a year of 0 or above 9999, or a day number outside years
// 1..9999; all other result fields are then zero.
// Steps after the accepting edge, each path ending in the done step: out of range
//   goes straight there; date to day runs year products, year sum and day sum;
//   day to date: epoch offset, year estimate, year search, month and day.
// A new start is taken in the same cycle done is high.
// The pace is set by a 16-step control store that drives the datapath multipliers
// and adders; the year search revisits three steps per candidate year.
// Reset clears busy, done and the step counter; no result is produced after it.
`include "persian_arithmetic_date_converter_assert.svh"

module persian_arithmetic_date_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pdc_pkg::pdc_in_t  cmd,
	output logic              busy,
	output logic              done,
	output pdc_pkg::pdc_out_t result
);
	import pdc_pkg::*;

	// Sequencer state
	logic     busy_q;
	logic     done_q;
	step_t    pc_q;
	ucode_t   cw;
	logic     take;
	logic     accept;

	// Datapath registers
	logic        kind_q;
	logic        status_q;
	logic [13:0] y_q;
	logic [3:0]  m_q;
	logic [4:0]  d_q;
	logic [21:0] fd_q;
	logic [21:0] t_q;
	logic [21:0] m365_q;
	logic [11:0] qa_q;
	logic [11:0] qb_q;
	logic [21:0] start_q;
	logic        leap_q;
	logic [8:0]  r_q;
	pdc_out_t    res_q;

	// Datapath intermediates
	logic [13:0] yv;
	logic [16:0] a21;
	logic [16:0] a29;
	logic [38:0] pa;
	logic [38:0] pb;
	logic [45:0] pe;
	logic [13:0] est;
	logic        in_bad;
	logic        date_ok;

	assign accept = start && !busy_q;
	assign cw     = ucode_rom(pc_q);

	// Range check of the incoming beat
	always_comb begin
		if (cmd.kind)
			in_bad = (cmd.in_fixed_day < EpochFixed) || (cmd.in_fixed_day >= LimitFixed);
		else
			in_bad = (cmd.in_year == 14'd0) || (cmd.in_year > MaxYear);
	end

	// Evaluate jump condition
	always_comb begin
		unique case (cw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_STATUS:    take = status_q;
			C_KIND:      take = kind_q;
			C_YEAR_NEXT: take = (y_q < MaxYear) && (start_q <= fd_q);
			default:     take = 1'b0;
		endcase
	end

	// Year operand, its products and the year estimate
	always_comb begin
		yv  = cw.ysel ? 14'(y_q + 14'd1) : y_q;
		a21 = 17'(yv) * 17'd8 + 17'd21;
		a29 = 17'(yv) * 17'd8 + 17'd29;
		pa  = 39'(a21) * 39'(K33);
		pb  = 39'(a29) * 39'(K33);
		pe  = 46'(t_q) * 46'(KYear);
		est = pe[YearShift +: 14];
	end

	// Step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (busy_q) begin
				pc_q <= take ? cw.target : step_t'(pc_q + 4'd1);
				if (cw.op == OP_DONE) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load on accept, else execute the current control word
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= cmd.kind;
			status_q <= in_bad;
			y_q      <= cmd.in_year;
			m_q      <= cmd.in_month;
			d_q      <= cmd.in_day;
			fd_q     <= cmd.in_fixed_day;
		end else if (busy_q) begin
			unique case (cw.op)
				OP_NOP: begin
				end
				OP_YMUL: begin
					m365_q <= 22'(22'(yv - 14'd1) * DaysPerYr);
					qa_q   <= pa[Q33Shift +: 12];
					qb_q   <= pb[Q33Shift +: 12];
				end
				OP_YSUM: begin
					start_q <= 22'(m365_q + 22'(qa_q) + EpochFixed);
					leap_q  <= (qb_q != qa_q);
				end
				OP_FIXSUM: begin
					t_q <= 22'(start_q - 22'd1 + 22'(cum_days(m_q, leap_q)) + 22'(d_q));
				end
				OP_SUBEP: begin
					t_q <= 22'(fd_q - EpochFixed);
				end
				OP_EST: begin
					y_q <= (est == 14'd0) ? 14'd1 : est;
				end
				OP_YINC: begin
					if (take)
						y_q <= 14'(y_q + 14'd1);
				end
				OP_RDAY: begin
					r_q <= 9'(fd_q - start_q);
				end
				OP_MON: begin
					m_q <= month_of(r_q);
				end
				OP_MDAY: begin
					d_q <= 5'(r_q - cum_days(m_q, 1'b0) + 9'd1);
				end
				OP_DONE: begin
					res_q.status        <= status_q;
					res_q.out_year      <= (kind_q && !status_q) ? y_q : 14'd0;
					res_q.out_month     <= (kind_q && !status_q) ? m_q : 4'd0;
					res_q.out_day       <= (kind_q && !status_q) ? d_q : 5'd0;
					res_q.out_fixed_day <= (!kind_q && !status_q) ? t_q : 22'd0;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = res_q;

	// Converted date lies within the calendar
	assign date_ok = (y_q != 14'd0) && (y_q <= MaxYear) && (m_q != 4'd0) &&
		(m_q <= 4'd12) && (d_q != 5'd0);

	// Checks
	`PDC_ASSERT_IMP(a_done_not_busy, done, !busy)
	`PDC_ASSERT_NXT(a_start_sets_busy, start && !busy, busy)
	`PDC_ASSERT_NXT(a_done_single, done, !done)
	`PDC_ASSERT_IMP(a_date_in_range, done && kind_q && !status_q, date_ok)

endmodule

/* dv/persian_arithmetic_date_converter_tb.sv */
`timescale 1ns / 1ps

module persian_arithmetic_date_converter_tb;
	import pdc_pkg::*;

	localparam logic KIND_TO_DAY  = 1'b0;
	localparam logic KIND_TO_DATE = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;
	localparam int unsigned LAST_YEAR  = 9999;
	localparam int unsigned N_RANDOM   = 1800;
	localparam int unsigned PRINT_CAP  = 200;

	// Calendar predictor and the queue of converted dates still owed by the block
	class calendar_ledger;
		pdc_out_t    owed_dates[$];
		int unsigned n_bad;

		function new();
			n_bad = 0;
		endfunction

		function bit leap_year(int unsigned y);
			return ((29 + 8 * y) % 33) < 8;
		endfunction

		function int unsigned month_days(int unsigned y, int unsigned m);
			if (m >= 1 && m <= 6)
				return 31;
			if (m >= 7 && m <= 11)
				return 30;
			if (m == 12)
				return leap_year(y) ? 30 : 29;
			return 0;
		endfunction

		// Fixed day of a date; months past twelve count only the whole year
		function int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
			int unsigned sum;
			sum = 0;
			for (int unsigned k = 1; k < m && k <= 12; k++)
				sum += month_days(y, k);
			return d + sum + 365 * (y - 1) + (21 + 8 * y) / 33
				+ (int'(EpochFixed) - 1);
		endfunction

		function pdc_out_t convert(pdc_in_t c);
			pdc_out_t    r;
			int unsigned y, m, fd;
			r = '0;
			r.status = STATUS_OK;
			if (c.kind == KIND_TO_DAY) begin
				y = c.in_year;
				if (y < 1 || y > LAST_YEAR)
					r.status = STATUS_RANGE;
				else
					r.out_fixed_day = 22'(day_number(y, c.in_month, c.in_day));
			end else begin
				fd = c.in_fixed_day;
				if (fd < int'(EpochFixed) || fd >= day_number(LAST_YEAR + 1, 1, 1)) begin
					r.status = STATUS_RANGE;
				end else begin
					// start below the true year, then walk forward
					y = (fd - int'(EpochFixed)) / 366 + 1;
					while (y < LAST_YEAR && day_number(y + 1, 1, 1) <= fd)
						y++;
					m = 1;
					while (m < 12 && fd > day_number(y, m, month_days(y, m)))
						m++;
					r.out_year  = 14'(y);
					r.out_month = 4'(m);
					r.out_day   = 5'(fd - day_number(y, m, 1) + 1);
				end
			end
			return r;
		endfunction

		task flag(string msg);
			n_bad++;
			if (n_bad <= PRINT_CAP)
				$display("[%0t] MISMATCH %s", $realtime, msg);
		endtask

		task log_cmd(pdc_in_t c);
			owed_dates.push_back(convert(c));
		endtask

		task check_result(pdc_out_t got);
			pdc_out_t want;
			if (owed_dates.size() == 0) begin
				flag("result beat with nothing outstanding");
				return;
			end
			want = owed_dates.pop_front();
			if (got.out_year !== want.out_year)
				flag($sformatf("out_year got %0d want %0d", got.out_year, want.out_year));
			if (got.out_month !== want.out_month)
				flag($sformatf("out_month got %0d want %0d", got.out_month, want.out_month));
			if (got.out_day !== want.out_day)
				flag($sformatf("out_day got %0d want %0d", got.out_day, want.out_day));
			if (got.out_fixed_day !== want.out_fixed_day)
				flag($sformatf("out_fixed_day got %0d want %0d",
					got.out_fixed_day, want.out_fixed_day));
			if (got.status !== want.status)
				flag($sformatf("status got %0b want %0b", got.status, want.status));
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	pdc_in_t  cmd;
	logic     busy;
	logic     done;
	pdc_out_t result;

	calendar_ledger ledger = new();

	persian_arithmetic_date_converter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels; retire a result before logging a beat taken on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_result(result);
			if (start && !busy)
				ledger.log_cmd(cmd);
		end
	end

	function automatic pdc_in_t date_cmd(int unsigned y, int unsigned m, int unsigned d);
		pdc_in_t c;
		c = pdc_in_t'({$urandom, $urandom});
		c.kind     = KIND_TO_DAY;
		c.in_year  = 14'(y);
		c.in_month = 4'(m);
		c.in_day   = 5'(d);
		return c;
	endfunction

	function automatic pdc_in_t day_cmd(int unsigned fd);
		pdc_in_t c;
		c = pdc_in_t'({$urandom, $urandom});
		c.kind         = KIND_TO_DATE;
		c.in_fixed_day = 22'(fd);
		return c;
	endfunction

	// Mostly well-formed dates and in-range day numbers, some raw noise
	function automatic pdc_in_t rand_cmd();
		pdc_in_t     c;
		int unsigned sel, y, m;
		c   = pdc_in_t'({$urandom, $urandom});
		sel = $urandom_range(0, 99);
		if (c.kind == KIND_TO_DAY) begin
			if (sel < 90) begin
				y = $urandom_range(1, LAST_YEAR);
				m = $urandom_range(1, 12);
				c = date_cmd(y, m, $urandom_range(1, ledger.month_days(y, m)));
			end
		end else begin
			if (sel < 15)
				c = day_cmd($urandom_range(0, 22'h3FFFFF));
			else if (sel < 40)
				c = day_cmd(ledger.day_number($urandom_range(1, LAST_YEAR + 1), 1, 1)
					- $urandom_range(0, 1));
			else
				c = day_cmd($urandom_range(int'(EpochFixed), int'(LimitFixed) - 1));
		end
		return c;
	endfunction

	// Hold start until the beat is taken; leave start high for the caller
	task send_cmd(pdc_in_t c);
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start for a random gap, mostly short, sometimes long
	task idle_gap(bit calm);
		int unsigned sel, n;
		sel = $urandom_range(0, 99);
		if (calm || sel < 40)
			n = 0;
		else if (sel < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task issue(pdc_in_t c, bit calm);
		send_cmd(c);
		idle_gap(calm);
	endtask

	initial begin
		bit calm;
		arst_n <= 1'b0;
		start  <= 1'b0;
		cmd    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// date to day: epoch, leap year end, range edges, odd months and days
		issue(date_cmd(1, 1, 1), 1'b0);
		issue(date_cmd(1, 12, 30), 1'b0);
		issue(date_cmd(9999, 12, 29), 1'b0);
		issue(date_cmd(9999, 12, 30), 1'b0);
		issue(date_cmd(0, 1, 1), 1'b0);
		issue(date_cmd(10000, 1, 1), 1'b0);
		issue(date_cmd(16383, 15, 31), 1'b0);
		issue(date_cmd(5, 0, 10), 1'b0);
		issue(date_cmd(5, 13, 1), 1'b0);
		issue(date_cmd(5, 15, 31), 1'b0);
		issue(date_cmd(5, 7, 0), 1'b0);
		issue(date_cmd(1403, 6, 31), 1'b0);
		issue(date_cmd(1402, 12, 31), 1'b0);

		// day to date: below and at the epoch, year turns, the upper edge
		issue(day_cmd(0), 1'b0);
		issue(day_cmd(int'(EpochFixed) - 1), 1'b0);
		issue(day_cmd(int'(EpochFixed)), 1'b0);
		issue(day_cmd(ledger.day_number(2, 1, 1) - 1), 1'b0);
		issue(day_cmd(ledger.day_number(1, 7, 1) - 1), 1'b0);
		issue(day_cmd(ledger.day_number(5000, 7, 1)), 1'b0);
		issue(day_cmd(int'(LimitFixed) - 1), 1'b0);
		issue(day_cmd(int'(LimitFixed)), 1'b0);
		issue(day_cmd(22'h3FFFFF), 1'b0);

		// random beats, with back-to-back stretches every so often
		calm = 1'b0;
		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			if (i % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			issue(rand_cmd(), calm);
		end
		start <= 1'b0;

		// drain, then give a late or extra beat time to show up
		while (ledger.owed_dates.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (ledger.n_bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
